// File: hw/rtl/tps_pkg.sv
// Shared types and constants of the triple pole parameter smoother.
// Used by the channel interfaces, the sequencer, the multiply-accumulate unit
// and the top level. Depends on nothing else.
package tps_pkg;

  localparam int COEF_W     = 32;
  localparam int GAIN_W     = 56;
  localparam int INTEG_W    = 64;
  localparam int INTEG_FRAC = 40;
  localparam int PROD_FRAC  = 88;
  localparam int MUL_W      = 33;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int ACC_W      = 128;
  localparam int HALF_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = GAIN_W;
  localparam int N_POLES    = 3;
  localparam int SEL_W      = 2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_COEF_A = 3'd0;
  localparam cfg_idx_t REG_COEF_B = 3'd1;
  localparam cfg_idx_t REG_COEF_C = 3'd2;
  localparam cfg_idx_t REG_GAIN_A = 3'd3;
  localparam cfg_idx_t REG_GAIN_B = 3'd4;
  localparam cfg_idx_t REG_GAIN_C = 3'd5;

  localparam logic [GAIN_W-1:0]  GAIN_ONE  = 56'h0001_0000_0000_0000;
  localparam logic [INTEG_W-1:0] INTEG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  // Weight of a partial product within the accumulator.
  typedef enum logic [1:0] {
    SH_0,
    SH_32,
    SH_64
  } shift_t;

  typedef struct packed {
    logic   issue;
    logic   clear;
    shift_t shift;
  } mac_req_t;

  typedef struct packed {
    mac_req_t             mac;
    logic                 src_gain;
    logic [SEL_W-1:0]     sel;
    logic                 a_hi;
    logic                 b_hi;
    logic                 integ_we;
    logic [SEL_W-1:0]     integ_sel;
    logic                 done;
  } tps_ctl_t;

endpackage

// File: hw/rtl/tps_ifs.sv
// Valid/ready channel interfaces of the triple pole parameter smoother:
// sample input, smoothed output and configuration write channel.
// Depends on tps_pkg.
interface tps_in_if #(parameter int SAMPLE_W = 25) ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] target_value;

  modport source (output valid, output target_value, input ready);
  modport sink   (input valid, input target_value, output ready);
endinterface

interface tps_out_if #(parameter int SAMPLE_W = 25) ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] smoothed_value;

  modport source (output valid, output smoothed_value, input ready);
  modport sink   (input valid, input smoothed_value, output ready);
endinterface

interface tps_cfg_if import tps_pkg::*; ();
  logic                  valid;
  logic                  ready;
  cfg_idx_t              reg_index;
  logic [CFG_DATA_W-1:0] wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// File: hw/rtl/triple_pole_parameter_smoother_core.sv
// Top level of the triple pole parameter smoother: configuration registers,
// integrator state, operand selection and output register.
// Depends on tps_pkg, tps_ifs, tps_mac and tps_seq.

// Each accepted sample keeps the block busy: 18 partial products go one per cycle
// through a single shared 33x33 signed multiplier (two per integrator update, four
// per weighted output term), then the product register and the accumulator drain
// and the output register is loaded. The input is ready only while no sample is being
// worked on, so the next sample can be taken in the idle cycle that follows and no
// sample is accepted before the previous one is through; if the previous result has not
// yet been taken the block holds at its last step until it is. Configuration writes are
// always taken and must only be made while the block is idle. Out of reset all
// coefficients are zero and gain_a is 1.0, so samples pass through unchanged.
module triple_pole_parameter_smoother_core
  import tps_pkg::*;
#(
  parameter int SAMPLE_FRAC_BITS = 24
) (
  input  logic      clk,
  input  logic      rst_n,
  tps_in_if.sink    in_chan,
  tps_out_if.source out_chan,
  tps_cfg_if.sink   cfg_chan
);

  localparam int SAMPLE_W  = SAMPLE_FRAC_BITS + 1;
  localparam int ADD_SHIFT = INTEG_FRAC - SAMPLE_FRAC_BITS;

  logic [COEF_W-1:0]   coef_r [N_POLES];
  logic [GAIN_W-1:0]   gain_r [N_POLES];
  logic [INTEG_W-1:0]  integ_r [N_POLES];
  logic [SAMPLE_W-1:0] sample_r;
  logic [SAMPLE_W-1:0] smoothed_r;
  logic [SAMPLE_W-1:0] smoothed_nxt;
  logic                out_valid_r;

  logic                    busy;
  logic                    out_free;
  logic                    in_acc;
  tps_ctl_t                ctl;
  logic [ACC_W-1:0]        acc;
  logic signed [MUL_W-1:0] op_a;
  logic signed [MUL_W-1:0] op_b;
  logic [COEF_W-1:0]       coef_sel;
  logic [GAIN_W-1:0]       gain_sel;
  logic [INTEG_W-1:0]      integ_sel;
  logic [INTEG_W-1:0]      add_term;
  logic [INTEG_W:0]        integ_sum;
  logic [INTEG_W-1:0]      integ_nxt;

  assign in_acc        = in_chan.valid && in_chan.ready;
  assign in_chan.ready = !busy;
  assign cfg_chan.ready = 1'b1;
  assign out_free      = !out_valid_r || out_chan.ready;

  tps_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc),
    .out_free (out_free),
    .busy     (busy),
    .ctl      (ctl)
  );

  always_comb begin
    case (ctl.sel)
      2'd1: begin
        coef_sel  = coef_r[1];
        gain_sel  = gain_r[1];
        integ_sel = integ_r[1];
      end
      2'd2: begin
        coef_sel  = coef_r[2];
        gain_sel  = gain_r[2];
        integ_sel = integ_r[2];
      end
      default: begin
        coef_sel  = coef_r[0];
        gain_sel  = gain_r[0];
        integ_sel = integ_r[0];
      end
    endcase
  end

  // Low halves enter as unsigned, high halves carry the sign.
  always_comb begin
    if (!ctl.src_gain) begin
      op_a = {1'b0, coef_sel};
    end else if (ctl.a_hi) begin
      op_a = MUL_W'(signed'(gain_sel[GAIN_W-1:HALF_W]));
    end else begin
      op_a = {1'b0, gain_sel[HALF_W-1:0]};
    end
    if (ctl.b_hi) begin
      op_b = {integ_sel[INTEG_W-1], integ_sel[INTEG_W-1:HALF_W]};
    end else begin
      op_b = {1'b0, integ_sel[HALF_W-1:0]};
    end
  end

  tps_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ctl.mac),
    .op_a  (op_a),
    .op_b  (op_b),
    .acc   (acc)
  );

  // The accumulator holds coef * integrator; bits 95:32 are its floor in Q24.40.
  // The sample is never negative, so only the upper bound can overflow.
  assign add_term  = INTEG_W'(sample_r) << ADD_SHIFT;
  assign integ_sum = {acc[INTEG_W+HALF_W-1], acc[INTEG_W+HALF_W-1:HALF_W]} +
                     {1'b0, add_term};
  assign integ_nxt = (!integ_sum[INTEG_W] && integ_sum[INTEG_W-1]) ? INTEG_MAX
                                                                   : integ_sum[INTEG_W-1:0];

  always_comb begin
    if (acc[ACC_W-1]) begin
      smoothed_nxt = '0;
    end else if (|acc[ACC_W-1:PROD_FRAC]) begin
      smoothed_nxt = {1'b1, {SAMPLE_FRAC_BITS{1'b0}}};
    end else begin
      smoothed_nxt = acc[PROD_FRAC -: SAMPLE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N_POLES; i++) begin
        coef_r[i]  <= '0;
        integ_r[i] <= '0;
      end
      gain_r[0]   <= GAIN_ONE;
      gain_r[1]   <= '0;
      gain_r[2]   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_chan.valid) begin
        unique case (cfg_chan.reg_index)
          REG_COEF_A: coef_r[0] <= cfg_chan.wr_data[COEF_W-1:0];
          REG_COEF_B: coef_r[1] <= cfg_chan.wr_data[COEF_W-1:0];
          REG_COEF_C: coef_r[2] <= cfg_chan.wr_data[COEF_W-1:0];
          REG_GAIN_A: gain_r[0] <= cfg_chan.wr_data[GAIN_W-1:0];
          REG_GAIN_B: gain_r[1] <= cfg_chan.wr_data[GAIN_W-1:0];
          REG_GAIN_C: gain_r[2] <= cfg_chan.wr_data[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (ctl.integ_we) begin
        case (ctl.integ_sel)
          2'd1:    integ_r[1] <= integ_nxt;
          2'd2:    integ_r[2] <= integ_nxt;
          default: integ_r[0] <= integ_nxt;
        endcase
      end
      if (ctl.done) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_acc) begin
      sample_r <= in_chan.target_value;
    end
    if (ctl.done) begin
      smoothed_r <= smoothed_nxt;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.smoothed_value = smoothed_r;

`ifndef SYNTHESIS
  a_done_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.done |-> (!out_valid_r || out_chan.ready))
    else $error("result word loaded while the previous one is still held");

  a_accept_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> busy)
    else $error("accepted sample did not start the sequencer");

  a_out_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (smoothed_r <= {1'b1, {SAMPLE_FRAC_BITS{1'b0}}}))
    else $error("smoothed word above 1.0");

  a_no_issue_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.mac.issue || ctl.integ_we) |-> busy)
    else $error("multiplier or integrator active while idle");
`endif

endmodule

// File: hw/rtl/tps_mac.sv
// Shared multiply-accumulate unit: one 33x33 signed multiplier with a
// product register, followed by a shifted add into a 128-bit accumulator.
// Depends on tps_pkg.
module tps_mac
  import tps_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  mac_req_t                req,
  input  logic signed [MUL_W-1:0] op_a,
  input  logic signed [MUL_W-1:0] op_b,
  output logic [ACC_W-1:0]        acc
);

  logic signed [PROD_W-1:0] prod_r;
  mac_req_t                 pend_r;
  logic [ACC_W-1:0]         acc_r;
  logic [ACC_W-1:0]         acc_nxt;
  logic [ACC_W-1:0]         prod_ext;
  logic [ACC_W-1:0]         prod_sh;

  assign prod_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  always_comb begin
    case (pend_r.shift)
      SH_0:    prod_sh = prod_ext;
      SH_32:   prod_sh = prod_ext << HALF_W;
      SH_64:   prod_sh = prod_ext << (2 * HALF_W);
      default: prod_sh = prod_ext;
    endcase
    acc_nxt = (pend_r.clear ? '0 : acc_r) + prod_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= req;
    end
    prod_r <= op_a * op_b;
    if (pend_r.issue) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

// File: hw/rtl/tps_seq.sv
// Step sequencer of the smoother: walks the integrator updates and the
// weighted output sum through the shared multiply-accumulate unit.
// Depends on tps_pkg.
module tps_seq
  import tps_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     out_free,
  output logic     busy,
  output tps_ctl_t ctl
);

  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] STEP_OUT0  = 5'd6;
  localparam logic [STEP_W-1:0] STEP_OUTN  = 5'd18;
  localparam logic [STEP_W-1:0] STEP_WR_A  = 5'd3;
  localparam logic [STEP_W-1:0] STEP_WR_B  = 5'd5;
  localparam logic [STEP_W-1:0] STEP_WR_C  = 5'd7;
  localparam logic [STEP_W-1:0] STEP_LAST  = 5'd19;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  state_t            state_r;
  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] wr_off;
  logic [STEP_W-1:0] out_off;

  assign wr_off  = step_r - STEP_WR_A;
  assign out_off = step_r - STEP_OUT0;

  always_comb begin
    ctl = '0;
    if (state_r == S_RUN) begin
      // Steps 0 to 5: two partial products per integrator, coef times each
      // half of the integrator. Steps 6 to 17: four per output term.
      if (step_r < STEP_OUT0) begin
        ctl.mac.issue = 1'b1;
        ctl.mac.clear = !step_r[0];
        ctl.mac.shift = step_r[0] ? SH_32 : SH_0;
        ctl.sel       = step_r[SEL_W:1];
        ctl.b_hi      = step_r[0];
      end else if (step_r < STEP_OUTN) begin
        ctl.mac.issue = 1'b1;
        ctl.mac.clear = (out_off == '0);
        ctl.src_gain  = 1'b1;
        ctl.sel       = out_off[3:2];
        ctl.a_hi      = out_off[1];
        ctl.b_hi      = out_off[0];
        case (out_off[1:0])
          2'd0:    ctl.mac.shift = SH_0;
          2'd3:    ctl.mac.shift = SH_64;
          default: ctl.mac.shift = SH_32;
        endcase
      end
      ctl.integ_we  = (step_r == STEP_WR_A) || (step_r == STEP_WR_B) ||
                      (step_r == STEP_WR_C);
      ctl.integ_sel = wr_off[SEL_W:1];
      ctl.done      = (step_r == STEP_LAST) && out_free;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          step_r <= '0;
          if (start) begin
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          if (step_r == STEP_LAST) begin
            if (out_free) begin
              state_r <= S_IDLE;
            end
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_r == S_RUN);

endmodule
